// File: hw/rtl/tfcq_pkg.sv
// Package for the touch finger count qualifier.
// Holds the frame and report word types, the touch kind codes and the
// debounce threshold tables. Depends on nothing.
package tfcq_pkg;

  localparam int unsigned ContactLimit = 2;
  localparam int unsigned CoordW = 10;

  localparam logic [3:0] CntMax = 4'd15;
  localparam logic [1:0] MaxIdx = 2'(ContactLimit);
  localparam int unsigned CalBit = 2;

  typedef enum logic [1:0] {
    KindNone   = 2'd0,
    KindSingle = 2'd1,
    KindUnsup  = 2'd2,
    KindDual   = 2'd3
  } touch_kind_e;

  typedef struct packed {
    logic [7:0] gesture_status;
    logic [7:0] first_x_high;
    logic [7:0] first_x_low;
    logic [7:0] first_y_high;
    logic [7:0] first_y_low;
    logic [7:0] second_x_high;
    logic [7:0] second_x_low;
    logic [7:0] second_y_high;
    logic [7:0] second_y_low;
  } frame_t;

  typedef struct packed {
    logic              report_valid;
    logic [1:0]        fingers;
    logic [CoordW-1:0] point_one_x;
    logic [CoordW-1:0] point_one_y;
    logic [CoordW-1:0] point_two_x;
    logic [CoordW-1:0] point_two_y;
    logic              unsupported_touch;
    logic              cal_request;
  } report_t;

  // A coordinate is the high byte shifted up by two, with the low byte ORed in.
  function automatic logic [CoordW-1:0] make_coord(logic [7:0] hi, logic [7:0] lo);
    return {hi, 2'b00} | {2'b00, lo};
  endfunction

  // Event count needed to qualify count cnt_idx, given the previous count.
  function automatic logic [3:0] thr_lookup(logic [1:0] cnt_idx, logic [1:0] prev);
    logic [3:0] thr;
    thr = 4'd0;
    case (cnt_idx)
      2'd0: begin
        case (prev)
          2'd0:    thr = 4'd0;
          2'd1:    thr = 4'd1;
          default: thr = 4'd5;
        endcase
      end
      2'd1: begin
        case (prev)
          2'd0:    thr = 4'd0;
          2'd1:    thr = 4'd0;
          default: thr = 4'd4;
        endcase
      end
      default: begin
        case (prev)
          2'd0:    thr = 4'd10;
          2'd1:    thr = 4'd8;
          default: thr = 4'd0;
        endcase
      end
    endcase
    return thr;
  endfunction

endpackage

// File: hw/rtl/tfcq_if.sv
// Valid/ready channel interfaces for the touch finger count qualifier.
// One carries touch frames in, the other reports out. Depends on tfcq_pkg.
interface tfcq_frame_if;
  logic             valid;
  logic             ready;
  tfcq_pkg::frame_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tfcq_report_if;
  logic              valid;
  logic              ready;
  tfcq_pkg::report_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/touch_finger_count_qualifier.sv
// Touch finger count qualifier: debounces the finger count of touch frames.
// Depends on tfcq_pkg and on the channel interfaces in tfcq_if.sv.
//
//   channel    direction  word        handshake
//   frame_i    in         frame_t     valid/ready, taken when both high
//   report_o   out        report_t    valid/ready, taken when both high
//
// A frame is taken into an input register, and the qualification logic then
// writes the report register and the counter state from it once the report
// register is free. One frame per cycle is sustained while reports are taken;
// the report word is offered from the report register until it is taken.
// Reset clears both stage valids, the qualified count and the counters.
// A stalled report holds the report register, and the input register then
// holds at most one further frame before ready falls.
module touch_finger_count_qualifier (
  input  logic clk_i,
  input  logic rst_ni,
  tfcq_frame_if.sink    frame_i,
  tfcq_report_if.source report_o
);
  import tfcq_pkg::*;

  logic        in_valid_q;
  frame_t      frm_q;
  logic        out_valid_q;
  report_t     rpt_q;
  report_t     rpt_d;
  logic [1:0]  qf_q;
  logic [1:0]  qf_d;
  logic [3:0]  cnt_q [ContactLimit+1];
  logic [3:0]  cnt_d [ContactLimit+1];

  logic        advance;
  logic        take;
  touch_kind_e kind;
  logic [1:0]  prev;
  logic [1:0]  idx;
  logic        unsup;
  logic [3:0]  cnt_bump;
  logic        qualify;
  logic [CoordW-1:0] p1x, p1y, p2x, p2y;

  assign advance = in_valid_q && (!out_valid_q || report_o.ready);
  assign frame_i.ready = !in_valid_q || advance;
  assign take = frame_i.valid && frame_i.ready;

  always_comb begin
    kind  = touch_kind_e'(frm_q.gesture_status[1:0]);
    prev  = (qf_q > MaxIdx) ? MaxIdx : qf_q;
    unsup = 1'b0;
    idx   = 2'd0;
    case (kind)
      KindNone:   idx = 2'd0;
      KindSingle: idx = 2'd1;
      KindDual:   idx = 2'd2;
      default:    unsup = 1'b1;
    endcase

    cnt_bump = (cnt_q[idx] == CntMax) ? CntMax : cnt_q[idx] + 4'd1;
    qualify  = !unsup && (cnt_bump >= thr_lookup(idx, prev));

    p1x = make_coord(frm_q.first_x_high, frm_q.first_x_low);
    p1y = make_coord(frm_q.first_y_high, frm_q.first_y_low);
    p2x = make_coord(frm_q.second_x_high, frm_q.second_x_low);
    p2y = make_coord(frm_q.second_y_high, frm_q.second_y_low);

    // In single touch, a fully non-zero second point takes the first slot.
    if (idx == 2'd1 && p2x != '0 && p2y != '0) begin
      p1x = p2x;
      p1y = p2y;
    end

    cnt_d = cnt_q;
    qf_d  = qf_q;
    if (!unsup) begin
      cnt_d[idx] = cnt_bump;
      if (qualify) begin
        qf_d = idx;
        if (idx != prev) begin
          for (int i = 0; i <= ContactLimit; i++) begin
            if (2'(i) != idx) begin
              cnt_d[i] = 4'd0;
            end
          end
        end
      end
    end

    rpt_d = '0;
    rpt_d.unsupported_touch = unsup;
    rpt_d.cal_request = !unsup && frm_q.gesture_status[CalBit];
    if (qualify) begin
      rpt_d.report_valid = 1'b1;
      rpt_d.fingers = idx;
      if (idx != 2'd0) begin
        rpt_d.point_one_x = p1x;
        rpt_d.point_one_y = p1y;
      end
      if (idx == 2'd2) begin
        rpt_d.point_two_x = p2x;
        rpt_d.point_two_y = p2y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      qf_q        <= 2'd0;
      for (int i = 0; i <= ContactLimit; i++) begin
        cnt_q[i] <= 4'd0;
      end
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        qf_q        <= qf_d;
        cnt_q       <= cnt_d;
      end else if (report_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      frm_q <= frame_i.data;
    end
    if (advance) begin
      rpt_q <= rpt_d;
    end
  end

  assign report_o.valid = out_valid_q;
  assign report_o.data  = rpt_q;

  a_qf_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qf_q != 2'd3)
    else $error("qualified count out of range");

  a_report_matches_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rpt_q.report_valid |-> rpt_q.fingers == qf_q)
    else $error("reported count differs from stored count");

  a_unsup_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rpt_q.unsupported_touch |->
      !rpt_q.report_valid && !rpt_q.cal_request)
    else $error("unsupported frame produced a report");

  a_unsup_holds_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && unsup |=> $stable(qf_q) && $stable(cnt_q[0]) && $stable(cnt_q[1])
      && $stable(cnt_q[2]))
    else $error("unsupported frame changed state");

endmodule
